// File: rtl/core/text_to_unsigned_any_base_top_macros.svh
// ----------------------------------------------------------------------------
// text_to_unsigned_any_base_top_macros
// Assertion macros used by the converter's top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_UNSIGNED_ANY_BASE_TOP_MACROS_SVH
`define TEXT_TO_UNSIGNED_ANY_BASE_TOP_MACROS_SVH

// same-cycle implication
`define TTUB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ttub: implication check failed");

// next-cycle implication
`define TTUB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ttub: next-cycle check failed");

`endif

// File: rtl/core/ttub_pkg.sv
// ----------------------------------------------------------------------------
// ttub_pkg
// Widths, codes and control/status types of the text to number converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ttub_pkg;

    localparam int SLOT_W       = 6;
    localparam int CHAR_W       = 8;
    localparam int BASE_W       = 7;
    localparam int VAL_W        = 64;
    localparam int NUM_SLOTS    = 64;
    localparam int DEF_MAX_BASE = 64;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

    // command field codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    // parse phase codes
    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_ENDED  = 2'd2;
    localparam logic [1:0] PH_OVER   = 2'd3;

    typedef struct packed {
        logic write_alpha;
        logic load_char;
        logic set_digits;
        logic scan_clear;
        logic scan_run;
        logic do_end;
        logic do_mac;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pass;       // character leaves the number untouched
        logic hit;
        logic miss;
        logic last;
        logic out_busy;
    } t_sts;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_W'(9)) && (c <= CHAR_W'(13))) || (c == CHAR_W'(32));
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ttub_if.sv
// ----------------------------------------------------------------------------
// ttub_if
// Valid/ready channels of the converter: input items, results, base register.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttub_in_if;
    import ttub_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [SLOT_W-1:0] slot;
    logic [CHAR_W-1:0] byte_req;
    logic              last_char;

    modport source (output valid, command, slot, byte_req, last_char, input ready);
    modport sink   (input valid, command, slot, byte_req, last_char, output ready);
endinterface

interface ttub_out_if;
    import ttub_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic             overflow;

    modport source (output valid, value, overflow, input ready);
    modport sink   (input valid, value, overflow, output ready);
endinterface

interface ttub_cfg_if;
    import ttub_pkg::*;
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base_length;

    modport source (output valid, base_length, input ready);
    modport sink   (input valid, base_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ttub_ctrl.sv
// ----------------------------------------------------------------------------
// ttub_ctrl
// Sequencer: takes items, walks the alphabet scan, multiply-add and result.
// ----------------------------------------------------------------------------
`default_nettype none

module ttub_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_command,
    input  wire ttub_pkg::t_sts i_sts,
    output logic               o_ready,
    output ttub_pkg::t_cmd     o_cmd
);
    import ttub_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_command == CMD_TEXT) begin
                        o_cmd.load_char = 1'b1;
                        n_state         = S_CHECK;
                    end else begin
                        o_cmd.write_alpha = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.pass) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.set_digits = 1'b1;
                    o_cmd.scan_clear = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                priority if (i_sts.hit) begin
                    n_state = S_MAC;
                end else if (i_sts.miss) begin
                    o_cmd.do_end = 1'b1;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            S_MAC: begin
                o_cmd.do_mac = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                priority if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    // result register still full
                    n_state = S_FIN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ttub_dp.sv
// ----------------------------------------------------------------------------
// ttub_dp
// Datapath: alphabet memory, slot scan, accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttub_dp #(
    parameter int MAX_BASE = ttub_pkg::DEF_MAX_BASE
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire ttub_pkg::t_cmd          i_cmd,
    input  wire logic [ttub_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [ttub_pkg::CHAR_W-1:0] i_byte_req,
    input  wire logic                    i_last_char,
    input  wire logic                    i_cfg_we,
    input  wire logic [ttub_pkg::BASE_W-1:0] i_base_length,
    output ttub_pkg::t_sts               o_sts,
    ttub_out_if.source                   o_out
);
    import ttub_pkg::*;

    localparam int BASE_LIM = (MAX_BASE < NUM_SLOTS) ? MAX_BASE : NUM_SLOTS;
    localparam logic [BASE_W-1:0] LIM = BASE_W'(BASE_LIM);
    localparam int MAC_W = VAL_W + BASE_W;

    logic [CHAR_W-1:0] r_mem [NUM_SLOTS];
    logic [CHAR_W-1:0] r_q;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic [BASE_W-1:0] r_base_length;
    logic [BASE_W-1:0] r_addr;      // one wider than a slot so it can reach the base
    logic [SLOT_W-1:0] r_cmp_addr;
    logic              r_cmp_vld;
    logic [1:0]        r_phase;
    logic [VAL_W-1:0]  r_acc;
    logic              r_out_vld;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_ovf;

    logic [BASE_W-1:0] w_base;
    logic              w_issue;
    logic [MAC_W-1:0]  w_mac;
    logic              w_mac_ovf;

    assign w_base  = (r_base_length > LIM) ? LIM : r_base_length;
    assign w_issue = i_cmd.scan_run && (r_addr < w_base);

    assign w_mac = ({{BASE_W{1'b0}}, r_acc} * {{VAL_W{1'b0}}, w_base})
                 + {{(MAC_W - SLOT_W){1'b0}}, r_cmp_addr};
    assign w_mac_ovf = |w_mac[MAC_W-1:VAL_W];

    assign o_sts.pass = (r_phase == PH_ENDED) || (r_phase == PH_OVER)
                     || ((r_phase == PH_SKIP) && is_blank(r_char));
    assign o_sts.hit      = r_cmp_vld && (r_q == r_char);
    assign o_sts.miss     = !r_cmp_vld && (r_addr >= w_base);
    assign o_sts.last     = r_last;
    assign o_sts.out_busy = r_out_vld && !o_out.ready;

    assign o_out.valid    = r_out_vld;
    assign o_out.value    = r_out_value;
    assign o_out.overflow = r_out_ovf;

    // alphabet: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_alpha) begin
            r_mem[i_slot] <= i_byte_req;
        end
        if (w_issue) begin
            r_q <= r_mem[r_addr[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_char <= i_byte_req;
            r_last <= i_last_char;
        end
        if (w_issue) begin
            r_cmp_addr <= r_addr[SLOT_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_value <= (r_phase == PH_OVER) ? '0 : r_acc;
            r_out_ovf   <= (r_phase == PH_OVER);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_length <= BASE_RESET;
            r_addr        <= '0;
            r_cmp_vld     <= 1'b0;
            r_phase       <= PH_SKIP;
            r_acc         <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base_length <= i_base_length;
            end

            if (i_cmd.scan_clear) begin
                r_addr    <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_cmp_vld <= w_issue;
                if (w_issue) begin
                    r_addr <= r_addr + BASE_W'(1);
                end
            end

            if (i_cmd.emit) begin
                r_phase <= PH_SKIP;
                r_acc   <= '0;
            end else if (i_cmd.set_digits) begin
                r_phase <= PH_DIGITS;
            end else if (i_cmd.do_end) begin
                r_phase <= PH_ENDED;
            end else if (i_cmd.do_mac) begin
                if (w_mac_ovf) begin
                    r_phase <= PH_OVER;
                    r_acc   <= '0;
                end else begin
                    r_acc <= w_mac[VAL_W-1:0];
                end
            end

            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/text_to_unsigned_any_base_top.sv
// Converts strings of text into unsigned 64-bit numbers over a loadable
// alphabet of up to 64 symbols; the base register selects how many slots are
// in use. A load item writes one alphabet slot. A text character is skipped
// when it is leading whitespace or follows an ended or overflowed number;
// otherwise the alphabet, kept in a memory with one write port and one
// registered read port, is scanned one slot per cycle from slot 0, and a
// match is followed by a 64-by-7 multiply-add while a miss ends the number.
// The result of a string is held in an output register, so a finished result
// waits there while the next characters are taken in.
`default_nettype none

`include "text_to_unsigned_any_base_top_macros.svh"

// ----------------------------------------------------------------------------
// text_to_unsigned_any_base_top
// Top level: joins sequencer and datapath to the item, result and base ports.
// ----------------------------------------------------------------------------
module text_to_unsigned_any_base_top #(
    parameter int MAX_BASE = ttub_pkg::DEF_MAX_BASE
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ttub_in_if.sink     i_in,
    ttub_cfg_if.sink    i_cfg,
    ttub_out_if.source  o_out
);
    import ttub_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    ttub_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_command (i_in.command),
        .i_sts     (w_sts),
        .o_ready   (w_in_ready),
        .o_cmd     (w_cmd)
    );

    ttub_dp #(
        .MAX_BASE (MAX_BASE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_slot        (i_in.slot),
        .i_byte_req    (i_in.byte_req),
        .i_last_char   (i_in.last_char),
        .i_cfg_we      (i_cfg.valid),
        .i_base_length (i_cfg.base_length),
        .o_sts         (w_sts),
        .o_out         (o_out)
    );

    `TTUB_ASSERT_IMPLY(a_hit_not_miss, i_clk, i_rst_n, w_sts.hit, !w_sts.miss)
    `TTUB_ASSERT_IMPLY(a_emit_slot_free, i_clk, i_rst_n, w_cmd.emit, !w_sts.out_busy)
    `TTUB_ASSERT_NEXT(a_text_blocks_in, i_clk, i_rst_n, w_in_ready && i_in.valid && i_in.command, !w_in_ready)
    `TTUB_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, w_cmd.emit, o_out.valid)

endmodule

`default_nettype wire
